// ----- design/bfq_pkg.sv -----
// ----------------------------------------------------------------------------
// bfq_pkg
// Types, constants and conversion functions shared by the bf16 to fp6 palette
// index quantizer.
// ----------------------------------------------------------------------------
package bfq_pkg;

  localparam int unsigned NumEntries  = 16;
  localparam int unsigned BankEntries = 8;
  localparam int unsigned GroupSize   = 4;
  localparam int unsigned GroupCount  = NumEntries / GroupSize;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned CodeW       = 6;
  localparam int unsigned FixW        = 9;
  localparam int unsigned DistW       = 9;
  localparam int unsigned ValueW      = 16;
  localparam int unsigned PackedW     = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 48;

  localparam logic [CfgIdxW-1:0] RegPaletteLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPaletteHigh = 2'd1;

  typedef logic [CodeW-1:0]         code_t;
  typedef logic signed [FixW-1:0]   fixed_t;
  typedef logic [DistW-1:0]         dist_t;
  typedef logic [IdxW-1:0]          idx_t;

  typedef logic [NumEntries-1:0][FixW-1:0]  fix_vec_t;
  typedef logic [NumEntries-1:0][DistW-1:0] dist_vec_t;

  typedef struct packed {
    dist_t delta;
    idx_t  idx;
  } cand_t;

  typedef cand_t [GroupCount-1:0] grp_vec_t;

  // Round a bf16 pattern to nearest-even into an fp6 e3m2 code.
  function automatic code_t bf16_to_fp6(input logic [ValueW-1:0] bits);
    logic               sign;
    logic [7:0]         expf;
    logic [6:0]         man;
    logic signed [9:0]  e;
    logic signed [9:0]  ex;
    logic signed [9:0]  ex_b;
    logic [2:0]         rounded;
    logic [1:0]         mant;
    logic               is_small;
    logic               tiny;
    logic               big;
    logic [4:0]         mag;
    sign    = bits[15];
    expf    = bits[14:7];
    man     = bits[6:0];
    e       = $signed({2'b00, expf}) - 10'sd127;
    rounded = {1'b0, man[6:5]} + {2'b00, man[4] & ((|man[3:0]) | man[5])};
    if (rounded[2]) begin
      mant = 2'b00;
      ex   = e + 10'sd1;
    end else begin
      mant = rounded[1:0];
      ex   = e;
    end
    is_small = ~mant[1];
    tiny  = (expf == 8'h00) || (e <= -10'sd7) || (ex <= -10'sd5);
    big   = (expf == 8'hFF) || (ex >= 10'sd5);
    ex_b  = ex + 10'sd3;
    mag   = {ex_b[2:0], mant};
    if (ex == -10'sd3) begin
      mag = is_small ? 5'd2 : 5'd3;
    end
    if (ex == -10'sd4) begin
      mag = is_small ? 5'd1 : 5'd2;
    end
    if (big) begin
      mag = 5'h1F;
    end
    return tiny ? code_t'(0) : {sign, mag};
  endfunction

  // Signed fixed-point form of an fp6 code in units of 2^-4, magnitude
  // masked to eight bits.
  function automatic fixed_t fp6_fixed(input code_t c);
    logic [2:0] exf;
    logic [2:0] sig;
    logic [8:0] wide;
    fixed_t     m;
    exf = c[4:2];
    if (exf == 3'd0) begin
      sig  = {1'b0, c[1:0]};
      wide = {6'b0, sig};
    end else begin
      sig  = {1'b1, c[1:0]};
      wide = {6'b0, sig} << (exf - 3'd1);
    end
    m = fixed_t'({1'b0, wide[7:0]});
    return c[5] ? -m : m;
  endfunction

  // Absolute difference of two fixed-point values, nine bits.
  function automatic dist_t abs_dist(input fixed_t a, input fixed_t b);
    logic signed [FixW:0] x;
    logic signed [FixW:0] ax;
    x  = $signed({a[FixW-1], a}) - $signed({b[FixW-1], b});
    ax = x[FixW] ? -x : x;
    return ax[DistW-1:0];
  endfunction

  // Keeps the first candidate unless the second is strictly nearer.
  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    return (b.delta < a.delta) ? b : a;
  endfunction

endpackage

// ----- design/bfq_cfg.sv -----
// ----------------------------------------------------------------------------
// bfq_cfg
// Palette registers and their fixed-point forms.
// ----------------------------------------------------------------------------
module bfq_cfg
  import bfq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output fix_vec_t            pal_fix_o
);

  logic [CfgDataW-1:0] pal_low_q;
  logic [CfgDataW-1:0] pal_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_low_q  <= '0;
      pal_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegPaletteLow:  pal_low_q  <= cfg_data_i;
        RegPaletteHigh: pal_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < BankEntries; i++) begin
      pal_fix_o[i]               = fp6_fixed(pal_low_q[CodeW*i +: CodeW]);
      pal_fix_o[i + BankEntries] = fp6_fixed(pal_high_q[CodeW*i +: CodeW]);
    end
  end

endmodule

// ----- design/bfq_front.sv -----
// ----------------------------------------------------------------------------
// bfq_front
// Converts both activations to fixed point, then forms their distances to
// every palette entry.
// ----------------------------------------------------------------------------
module bfq_front
  import bfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [ValueW-1:0] even_value_i,
  input  logic [ValueW-1:0] odd_value_i,
  input  fix_vec_t          pal_fix_i,
  output logic              valid_o,
  output dist_vec_t         even_dist_o,
  output dist_vec_t         odd_dist_o
);

  logic      conv_valid_q;
  fixed_t    even_fix_q;
  fixed_t    odd_fix_q;
  logic      dist_valid_q;
  dist_vec_t even_dist_d;
  dist_vec_t odd_dist_d;
  dist_vec_t even_dist_q;
  dist_vec_t odd_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_valid_q <= 1'b0;
      dist_valid_q <= 1'b0;
    end else begin
      conv_valid_q <= valid_i;
      dist_valid_q <= conv_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    even_fix_q  <= fp6_fixed(bf16_to_fp6(even_value_i));
    odd_fix_q   <= fp6_fixed(bf16_to_fp6(odd_value_i));
    even_dist_q <= even_dist_d;
    odd_dist_q  <= odd_dist_d;
  end

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      even_dist_d[i] = abs_dist(even_fix_q, $signed(pal_fix_i[i]));
      odd_dist_d[i]  = abs_dist(odd_fix_q, $signed(pal_fix_i[i]));
    end
  end

  assign valid_o     = dist_valid_q;
  assign even_dist_o = even_dist_q;
  assign odd_dist_o  = odd_dist_q;

endmodule

// ----- design/bfq_argmin.sv -----
// ----------------------------------------------------------------------------
// bfq_argmin
// Two-level registered search for the nearest palette entry of each lane,
// lower index first on ties, and packing of the two indices.
// ----------------------------------------------------------------------------
module bfq_argmin
  import bfq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dist_vec_t          even_dist_i,
  input  dist_vec_t          odd_dist_i,
  output logic               valid_o,
  output logic [PackedW-1:0] packed_o
);

  logic               grp_valid_q;
  grp_vec_t           even_grp_d;
  grp_vec_t           odd_grp_d;
  grp_vec_t           even_grp_q;
  grp_vec_t           odd_grp_q;
  logic               out_valid_q;
  cand_t              even_best;
  cand_t              odd_best;
  logic [PackedW-1:0] packed_q;

  always_comb begin
    for (int g = 0; g < GroupCount; g++) begin
      even_grp_d[g] = '{delta: even_dist_i[GroupSize*g], idx: idx_t'(GroupSize*g)};
      odd_grp_d[g]  = '{delta: odd_dist_i[GroupSize*g], idx: idx_t'(GroupSize*g)};
      for (int k = 1; k < GroupSize; k++) begin
        even_grp_d[g] = cand_min(even_grp_d[g],
            '{delta: even_dist_i[GroupSize*g + k], idx: idx_t'(GroupSize*g + k)});
        odd_grp_d[g]  = cand_min(odd_grp_d[g],
            '{delta: odd_dist_i[GroupSize*g + k], idx: idx_t'(GroupSize*g + k)});
      end
    end
  end

  always_comb begin
    even_best = even_grp_q[0];
    odd_best  = odd_grp_q[0];
    for (int g = 1; g < GroupCount; g++) begin
      even_best = cand_min(even_best, even_grp_q[g]);
      odd_best  = cand_min(odd_best, odd_grp_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      grp_valid_q <= valid_i;
      out_valid_q <= grp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    even_grp_q <= even_grp_d;
    odd_grp_q  <= odd_grp_d;
    packed_q   <= {odd_best.idx, even_best.idx};
  end

  assign valid_o  = out_valid_q;
  assign packed_o = packed_q;

endmodule

// ----- design/bf16_to_fp6_lut_index_quantizer.sv -----
// ----------------------------------------------------------------------------
// A transfer at start reaches the done_o strobe through the register stages below.
// Throughput: one activation pair per cycle; busy stays low.
// The four register stages are conversion, distances, group minimum and
// final minimum; the receiver cannot stall, so nothing is held back.
// Reset clears the stage valid bits and both palette registers to zero.
// ----------------------------------------------------------------------------
// bf16_to_fp6_lut_index_quantizer
// Quantizes two bf16 activations to fp6 e3m2 and returns the index of the
// nearest entry of a configured 16-entry palette for each, packed in a byte.
// ----------------------------------------------------------------------------
module bf16_to_fp6_lut_index_quantizer
  import bfq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ValueW-1:0]   even_value_i,
  input  logic [ValueW-1:0]   odd_value_i,
  output logic                done_o,
  output logic [PackedW-1:0]  packed_indices_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  fix_vec_t  pal_fix;
  logic      dist_valid;
  dist_vec_t even_dist;
  dist_vec_t odd_dist;

  assign busy = 1'b0;

  bfq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pal_fix_o   (pal_fix)
  );

  bfq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start && !busy),
    .even_value_i (even_value_i),
    .odd_value_i  (odd_value_i),
    .pal_fix_i    (pal_fix),
    .valid_o      (dist_valid),
    .even_dist_o  (even_dist),
    .odd_dist_o   (odd_dist)
  );

  bfq_argmin u_argmin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dist_valid),
    .even_dist_i (even_dist),
    .odd_dist_i  (odd_dist),
    .valid_o     (done_o),
    .packed_o    (packed_indices_o)
  );

endmodule
